[hdl/lwbc_pkg.sv]
// Package for the LRU write-back block cache controller.
// Types, codes and constants; no dependencies.
package lwbc_pkg;

  localparam int CacheSlotsDefault = 16;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [2:0] ACT_HIT    = 3'd0;
  localparam logic [2:0] ACT_EVICT  = 3'd1;
  localparam logic [2:0] ACT_FILL   = 3'd2;
  localparam logic [2:0] ACT_MARKED = 3'd3;
  localparam logic [2:0] ACT_FLUSHW = 3'd4;
  localparam logic [2:0] ACT_DONE   = 3'd5;
  localparam logic [2:0] ACT_RANGE  = 3'd6;
  localparam logic [2:0] ACT_NOTC   = 3'd7;

  localparam logic [1:0] REG_TOTAL = 2'd0;
  localparam logic [1:0] REG_LBS   = 2'd1;
  localparam logic [1:0] REG_DLS   = 2'd2;
  localparam logic [1:0] REG_WR    = 2'd3;

  localparam int CfgIdxW = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [31:0] target_block;
    logic [31:0] sector_address;
    logic [16:0] sector_count;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_FLUSH, S_EMIT
  } be_state_t;

endpackage

[hdl/lwbc_front.sv]
// Front end: accepts input beats, drops unused operations, queues the rest.
// Depends on lwbc_pkg.
module lwbc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lwbc_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output lwbc_pkg::in_item_t q_data
);
  lwbc_pkg::in_item_t buf0, buf1;
  logic [1:0] cnt;

  logic push, pop;
  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready && (in_data.operation != 2'd3);
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (cnt == 2'd2) ? buf1 : in_data;
      if (push && cnt == 2'd2) buf1 <= in_data;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= in_data;
      else buf1 <= in_data;
    end
  end
endmodule

[hdl/lwbc_back.sv]
// Back end: tag scan, recency update, writeback/fill and flush sequencing.
// Depends on lwbc_pkg.
module lwbc_back #(
  parameter int CACHE_SLOTS = lwbc_pkg::CacheSlotsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  lwbc_pkg::in_item_t  q_data,
  input  logic [31:0]         total_blocks,
  input  logic [2:0]          log_block_size,
  input  logic [4:0]          device_log_sector,
  input  logic                writable,
  output logic                out_valid,
  input  logic                out_ready,
  output lwbc_pkg::out_item_t out_data
);
  localparam int PW = $clog2(CACHE_SLOTS);

  logic [PW-1:0] order [CACHE_SLOTS];
  logic [31:0]   tag   [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] vld, drt;

  lwbc_pkg::be_state_t state, state_next;
  lwbc_pkg::in_item_t cur;
  logic [PW-1:0] pos;
  logic          found;
  logic [PW-1:0] hpos;
  logic [PW-1:0] held;
  logic          filling;

  logic [PW-1:0] ps;
  assign ps = order[pos];

  // geometry
  logic signed [6:0] sl;
  logic geo_ok;
  logic [4:0] sh;
  assign sl = $signed({4'd0, log_block_size}) + 7'sd10 - $signed({2'd0, device_log_sector});
  assign geo_ok = (sl >= 0) && (sl <= 16);
  assign sh = sl[4:0];

  function automatic lwbc_pkg::out_item_t cmd(input logic [2:0] a, input logic [PW-1:0] s,
      input logic [31:0] b, input logic l, input logic [4:0] k);
    lwbc_pkg::out_item_t o;
    o.action = a;
    o.slot = 4'(s);
    o.target_block = b;
    o.sector_address = b << k;
    o.sector_count = 17'd1 << k;
    o.last = l;
    return o;
  endfunction

  function automatic lwbc_pkg::out_item_t simple(input logic [2:0] a, input logic [PW-1:0] s,
      input logic [31:0] b);
    lwbc_pkg::out_item_t o;
    o = '0;
    o.action = a;
    o.slot = 4'(s);
    o.target_block = b;
    o.last = 1'b1;
    return o;
  endfunction

  assign q_ready = (state == lwbc_pkg::S_IDLE);
  logic out_free;
  assign out_free = !out_valid || out_ready;

  // a beat is loaded into the output register this cycle
  logic emit;
  assign emit = out_free && ((state == lwbc_pkg::S_DECIDE) || (state == lwbc_pkg::S_EMIT) ||
    (state == lwbc_pkg::S_FLUSH && (drt[ps] || pos == '0)));

  always_ff @(posedge clk) begin
    if (rst) state <= lwbc_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lwbc_pkg::S_IDLE:
        if (q_valid) state_next = (q_data.operation == lwbc_pkg::OP_FLUSH) ?
          (writable ? lwbc_pkg::S_FLUSH : lwbc_pkg::S_EMIT) : lwbc_pkg::S_SCAN;
      lwbc_pkg::S_SCAN:
        if (pos == '0) state_next = lwbc_pkg::S_DECIDE;
      lwbc_pkg::S_DECIDE: state_next = state;
      lwbc_pkg::S_SHIFT:
        if (pos == PW'(CACHE_SLOTS - 1)) state_next = lwbc_pkg::S_IDLE;
      lwbc_pkg::S_FLUSH: state_next = state;
      lwbc_pkg::S_EMIT:
        if (out_free) state_next = lwbc_pkg::S_IDLE;
      default: state_next = lwbc_pkg::S_IDLE;
    endcase
    if (state == lwbc_pkg::S_DECIDE && out_free) begin
      if (found) state_next = (hpos == PW'(CACHE_SLOTS - 1)) ?
        lwbc_pkg::S_IDLE : lwbc_pkg::S_SHIFT;
      else if (cur.operation == lwbc_pkg::OP_MARK) state_next = lwbc_pkg::S_IDLE;
      else if (drt[order[0]] && !filling) begin
        if (!(geo_ok && tag[order[0]] < total_blocks)) state_next = lwbc_pkg::S_IDLE;
      end else if (!(geo_ok && cur.block_number < total_blocks)) state_next = lwbc_pkg::S_IDLE;
      else state_next = lwbc_pkg::S_SHIFT;
    end
    if (state == lwbc_pkg::S_FLUSH && out_free) begin
      if (drt[ps] && !(geo_ok && tag[ps] < total_blocks)) state_next = lwbc_pkg::S_IDLE;
      else if (pos == '0) state_next = drt[ps] ? lwbc_pkg::S_EMIT : lwbc_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_SLOTS; i++) order[i] <= PW'(i);
      vld <= '0;
      drt <= '0;
    end else begin
      unique case (state)
        lwbc_pkg::S_IDLE:
          if (q_valid) begin
            cur <= q_data;
            pos <= PW'(CACHE_SLOTS - 1);
            found <= 1'b0;
            filling <= 1'b0;
          end
        lwbc_pkg::S_SCAN: begin
          if (!found && vld[ps] && tag[ps] == cur.block_number) begin
            found <= 1'b1;
            hpos <= pos;
          end
          pos <= pos - PW'(1);
        end
        lwbc_pkg::S_DECIDE:
          if (out_free) begin
            if (found) begin
              if (cur.operation == lwbc_pkg::OP_MARK) begin
                out_data <= simple(lwbc_pkg::ACT_MARKED, order[hpos], cur.block_number);
                drt[order[hpos]] <= 1'b1;
              end else
                out_data <= simple(lwbc_pkg::ACT_HIT, order[hpos], cur.block_number);
              pos <= hpos;
              held <= order[hpos];
            end else if (cur.operation == lwbc_pkg::OP_MARK) begin
              out_data <= simple(lwbc_pkg::ACT_NOTC, '0, cur.block_number);
            end else if (drt[order[0]] && !filling) begin
              filling <= 1'b1;
              if (geo_ok && tag[order[0]] < total_blocks)
                out_data <= cmd(lwbc_pkg::ACT_EVICT, order[0], tag[order[0]], 1'b0, sh);
              else
                out_data <= simple(lwbc_pkg::ACT_RANGE, order[0], tag[order[0]]);
            end else begin
              drt[order[0]] <= 1'b0;
              if (geo_ok && cur.block_number < total_blocks) begin
                out_data <= cmd(lwbc_pkg::ACT_FILL, order[0], cur.block_number, 1'b1, sh);
                tag[order[0]] <= cur.block_number;
                vld[order[0]] <= 1'b1;
                pos <= '0;
                held <= order[0];
              end else begin
                out_data <= simple(lwbc_pkg::ACT_RANGE, order[0], cur.block_number);
                vld[order[0]] <= 1'b0;
              end
            end
          end
        lwbc_pkg::S_SHIFT: begin
          if (pos == PW'(CACHE_SLOTS - 1)) order[pos] <= held;
          else order[pos] <= order[pos + PW'(1)];
          pos <= pos + PW'(1);
        end
        lwbc_pkg::S_FLUSH:
          if (out_free) begin
            if (drt[ps]) begin
              if (geo_ok && tag[ps] < total_blocks) begin
                out_data <= cmd(lwbc_pkg::ACT_FLUSHW, ps, tag[ps], 1'b0, sh);
                drt[ps] <= 1'b0;
              end else
                out_data <= simple(lwbc_pkg::ACT_RANGE, ps, tag[ps]);
            end else if (pos == '0) begin
              out_data <= simple(lwbc_pkg::ACT_DONE, '0, '0);
            end
            pos <= pos - PW'(1);
          end
        lwbc_pkg::S_EMIT:
          if (out_free) begin
            out_data <= simple(lwbc_pkg::ACT_DONE, '0, '0);
          end
        default: ;
      endcase
    end
  end
endmodule

[hdl/lru_writeback_block_cache.sv]
// A read/mark scans all CACHE_SLOTS positions, then a recency shift of up to
// CACHE_SLOTS positions; flush walks one slot per cycle unless the output stalls.
// The back end works on one item at a time.
// A two-entry queue lets the front take items while the back works.
// Reset (rst, synchronous): recency identity, all slots invalid and clean,
// registers 0, 0, 9, 0.
module lru_writeback_block_cache #(
  parameter int CACHE_SLOTS = lwbc_pkg::CacheSlotsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lwbc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [lwbc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]         cfg_data
);
  logic [31:0] total_blocks;
  logic [2:0]  log_block_size;
  logic [4:0]  device_log_sector;
  logic        writable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= '0;
      log_block_size <= '0;
      device_log_sector <= 5'd9;
      writable <= 1'b0;
    end else if (cfg_valid && cfg_index[31:2] == '0) begin
      unique case (cfg_index[1:0])
        lwbc_pkg::REG_TOTAL: total_blocks <= cfg_data;
        lwbc_pkg::REG_LBS:   log_block_size <= cfg_data[2:0];
        lwbc_pkg::REG_DLS:   device_log_sector <= cfg_data[4:0];
        lwbc_pkg::REG_WR:    writable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic q_valid, q_ready;
  lwbc_pkg::in_item_t q_data;

  lwbc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  lwbc_back #(.CACHE_SLOTS(CACHE_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .total_blocks, .log_block_size, .device_log_sector, .writable,
    .out_valid, .out_ready, .out_data
  );
endmodule

[hdl/lwbc_checker.sv]
// Port-level checker for the block cache controller, bound to the top level.
// Depends on lwbc_pkg.
module lwbc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input lwbc_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action == lwbc_pkg::ACT_DONE |-> out_data.last)
    else $error("done without last");
  a_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == lwbc_pkg::ACT_EVICT ||
    out_data.action == lwbc_pkg::ACT_FLUSHW) |-> !out_data.last)
    else $error("writeback marked last");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action == lwbc_pkg::ACT_HIT |-> out_data.sector_count == '0)
    else $error("hit carries sector count");
endmodule

bind lru_writeback_block_cache lwbc_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_data
);

[verif/lru_writeback_block_cache_check.sv]
// Checker for the LRU write-back block cache: watches the request, response
// and register channels, predicts every response beat and compares it.
// Depends on lwbc_pkg.
`timescale 1ns / 100ps
module lru_writeback_block_cache_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lwbc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lwbc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [31:0]         cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  import lwbc_pkg::*;

  localparam int N = 16;

  logic [31:0] blk_total;
  logic [2:0]  blk_log;
  logic [4:0]  sec_log;
  logic        rw;
  logic [3:0]  lru_list [N];
  logic [31:0] tag [N];
  logic        vld [N];
  logic        dty [N];
  out_item_t   want_q [$];

  assign pending = want_q.size();

  function automatic out_item_t mk(logic [2:0] a, logic [3:0] s, logic [31:0] t,
                                   logic [31:0] ad, logic [16:0] c, logic l);
    out_item_t r;
    r.action = a; r.slot = s; r.target_block = t;
    r.sector_address = ad; r.sector_count = c; r.last = l;
    return r;
  endfunction

  function automatic bit sector_cmd(logic [31:0] b, output logic [31:0] ad,
                                    output logic [16:0] c);
    int s;
    s = int'(blk_log) + 10 - int'(sec_log);
    ad = '0; c = '0;
    if (s < 0 || s > 16 || b >= blk_total) return 0;
    ad = b << s;
    c = 17'd1 << s;
    return 1;
  endfunction

  task automatic promote(int p);
    logic [3:0] h;
    if (p < 0 || p >= N - 1) return;
    h = lru_list[p];
    for (int i = p; i < N - 1; i++) lru_list[i] = lru_list[i + 1];
    lru_list[N - 1] = h;
  endtask

  function automatic int find_pos(logic [31:0] b);
    for (int i = N - 1; i >= 0; i--)
      if (vld[lru_list[i]] && tag[lru_list[i]] == b) return i;
    return -1;
  endfunction

  task automatic predict_cache(in_item_t it);
    int p;
    logic [3:0] s;
    logic [31:0] ad;
    logic [16:0] c;
    case (it.operation)
      OP_READ: begin
        p = find_pos(it.block_number);
        if (p >= 0) begin
          s = lru_list[p];
          promote(p);
          want_q.push_back(mk(ACT_HIT, s, it.block_number, '0, '0, 1'b1));
          return;
        end
        s = lru_list[0];
        if (dty[s]) begin
          if (!sector_cmd(tag[s], ad, c)) begin
            want_q.push_back(mk(ACT_RANGE, s, tag[s], '0, '0, 1'b1));
            return;
          end
          want_q.push_back(mk(ACT_EVICT, s, tag[s], ad, c, 1'b0));
        end
        if (!sector_cmd(it.block_number, ad, c)) begin
          vld[s] = 0; dty[s] = 0;
          want_q.push_back(mk(ACT_RANGE, s, it.block_number, '0, '0, 1'b1));
          return;
        end
        tag[s] = it.block_number; vld[s] = 1; dty[s] = 0;
        promote(0);
        want_q.push_back(mk(ACT_FILL, s, it.block_number, ad, c, 1'b1));
      end
      OP_MARK: begin
        p = find_pos(it.block_number);
        if (p < 0) begin
          want_q.push_back(mk(ACT_NOTC, '0, it.block_number, '0, '0, 1'b1));
          return;
        end
        s = lru_list[p];
        dty[s] = 1;
        promote(p);
        want_q.push_back(mk(ACT_MARKED, s, it.block_number, '0, '0, 1'b1));
      end
      OP_FLUSH: begin
        if (rw) begin
          for (int i = N - 1; i >= 0; i--) begin
            s = lru_list[i];
            if (dty[s]) begin
              if (!sector_cmd(tag[s], ad, c)) begin
                want_q.push_back(mk(ACT_RANGE, s, tag[s], '0, '0, 1'b1));
                return;
              end
              want_q.push_back(mk(ACT_FLUSHW, s, tag[s], ad, c, 1'b0));
              dty[s] = 0;
            end
          end
        end
        want_q.push_back(mk(ACT_DONE, '0, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        lru_list[i] = i[3:0]; tag[i] = '0; vld[i] = 0; dty[i] = 0;
      end
      blk_total = '0; blk_log = '0; sec_log = 5'd9; rw = 0;
      want_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index[31:2] == '0)
        case (cfg_index[1:0])
          REG_TOTAL: blk_total = cfg_data;
          REG_LBS:   blk_log = cfg_data[2:0];
          REG_DLS:   sec_log = cfg_data[4:0];
          REG_WR:    rw = cfg_data[0];
        endcase
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, out_data);
          errors++;
        end else begin
          w = want_q.pop_front();
          if (w !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, w, out_data);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) predict_cache(in_data);
    end
  end
endmodule

[verif/lru_writeback_block_cache_test.sv]
// Testbench top for the LRU write-back block cache: drives requests and
// register writes, stalls the response side, and reports the verdict.
// Depends on lwbc_pkg, the block and lru_writeback_block_cache_check.
`timescale 1ns / 100ps
module lru_writeback_block_cache_test;
  import lwbc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] cfg_index = '0, cfg_data = '0;
  in_item_t in_data = '0;
  out_item_t out_data;
  int errors, pending;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  bit done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lru_writeback_block_cache dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lru_writeback_block_cache_check chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(negedge clk)
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);

  // valid stays high on return; the caller drops it when the burst ends
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= {30'b0, idx};
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic send_beat(logic [1:0] op, logic [31:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_data <= {op, b};
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic setup(logic [31:0] tot, logic [2:0] lb, logic [4:0] ds, logic w);
    in_valid <= 0;
    drain();
    write_reg(REG_TOTAL, tot);
    write_reg(REG_LBS, {29'b0, lb});
    write_reg(REG_DLS, {27'b0, ds});
    write_reg(REG_WR, {31'b0, w});
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_block(logic [31:0] tot);
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(23) + (tot > 40 ? tot - 40 : 0);
  endfunction

  task automatic random_phase(int n, logic [31:0] tot);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60) send_beat(OP_READ, pick_block(tot));
      else if (r < 85) send_beat(OP_MARK, pick_block(tot));
      else if (r < 97) send_beat(OP_FLUSH, $urandom());
      else send_beat(2'd3, $urandom());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: defaults, then extremes of geometry and range
    send_beat(OP_READ, 0);
    send_beat(OP_MARK, 0);
    send_beat(OP_FLUSH, 0);
    send_beat(2'd3, 32'hFFFF_FFFF);
    setup(32'hFFFF_FFFF, 3'd6, 5'd0, 1);
    send_beat(OP_READ, 32'hFFFF_FFFE);
    send_beat(OP_FLUSH, 0);
    setup(32'hFFFF_FFFF, 3'd6, 5'd16, 1);
    send_beat(OP_READ, 32'hFFFF_FFFE);
    send_beat(OP_READ, 32'hFFFF_FFFF);
    send_beat(OP_MARK, 32'hFFFF_FFFE);
    send_beat(OP_MARK, 5);
    send_beat(OP_READ, 32'hFFFF_FFFE);
    send_beat(OP_FLUSH, 0);
    send_beat(OP_MARK, 32'hFFFF_FFFE);
    setup(32'hFFFF_FFFF, 3'd0, 5'd0, 0);
    send_beat(OP_FLUSH, 0);
    setup(10, 3'd2, 5'd9, 1);
    send_beat(OP_FLUSH, 0);
    for (int i = 0; i < 17; i++) send_beat(OP_READ, i[31:0] % 11);
    // random phases across settings and idling
    setup(20, 3'd3, 5'd12, 1);
    random_phase(22, 20);
    send_idle = 75;
    setup(32'hFFFF_FFF0, 3'd6, 5'd9, 1);
    random_phase(22, 32'hFFFF_FFF0);
    send_idle = 0; recv_stall = 75;
    setup(24, 3'd1, 5'd10, 1);
    random_phase(22, 24);
    send_idle = 38; recv_stall = 38;
    setup(30, 3'($urandom_range(6)), 5'($urandom_range(16)), 1'($urandom_range(1)));
    random_phase(22, 30);
    send_idle = 0; recv_stall = 0;
    in_valid <= 0;
    drain();
    hold_off = 1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      begin
        random_phase(12, 30);
        in_valid <= 0;
      end
    join
    drain();
    done = 1;
  end

  initial begin
    wait (done);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[filelist.f]
hdl/lwbc_pkg.sv
hdl/lwbc_front.sv
hdl/lwbc_back.sv
hdl/lru_writeback_block_cache.sv
hdl/lwbc_checker.sv
verif/lru_writeback_block_cache_check.sv
verif/lru_writeback_block_cache_test.sv
